FILE: rtl/assert_macros.svh
// assertion helpers used by the checker file bid_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BID_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("bytecode deframer check failed");

// antecedent implies consequent in the next cycle
`define BID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("bytecode deframer check failed");

`endif

FILE: rtl/bid_pkg.sv
`default_nettype none

package bid_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned VTYPE_W = 4;
  localparam int unsigned IMM_W   = 64;
  localparam int unsigned REG_W   = 8;
  localparam int unsigned LEFT_W  = 4;
  localparam int unsigned POS_W   = 3;

  // output tdata: immediate, reg_first, reg_second
  localparam int unsigned OUT_DATA_W = IMM_W + 2 * REG_W;
  // output tuser: kind, value_type
  localparam int unsigned OUT_USER_W = KIND_W + VTYPE_W;

  // result kinds; opcodes 0..9 use the same codes
  typedef enum logic [KIND_W-1:0] {
    KIND_DUMP     = 4'd0,
    KIND_MOV      = 4'd1,
    KIND_POPR     = 4'd2,
    KIND_COPYR    = 4'd3,
    KIND_PUSH     = 4'd4,
    KIND_POP      = 4'd5,
    KIND_GET      = 4'd6,
    KIND_SET      = 4'd7,
    KIND_COPY     = 4'd8,
    KIND_SWAP     = 4'd9,
    KIND_BAD_TYPE = 4'd10
  } kind_e;

  // value type codes
  localparam logic [VTYPE_W-1:0] TYPE_I8  = 4'd4;
  localparam logic [VTYPE_W-1:0] TYPE_I16 = 4'd5;
  localparam logic [VTYPE_W-1:0] TYPE_I32 = 4'd6;
  localparam logic [VTYPE_W-1:0] TYPE_F32 = 4'd8;
  localparam logic [VTYPE_W-1:0] TYPE_F64 = 4'd9;

  typedef struct packed {
    kind_e               kind;
    logic [VTYPE_W-1:0]  value_type;
    logic [IMM_W-1:0]    immediate;
    logic [REG_W-1:0]    reg_first;
    logic [REG_W-1:0]    reg_second;
  } result_t;

  // immediate length in bytes for a valid type code
  function automatic logic [LEFT_W-1:0] imm_length(input logic [VTYPE_W-1:0] t);
    logic [LEFT_W-1:0] len;
    if (t == TYPE_F32) begin
      len = 4'd4;
    end else if (t == TYPE_F64) begin
      len = 4'd8;
    end else begin
      len = LEFT_W'(1) << t[1:0];
    end
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bid_in_reg.sv
`default_nettype none

module bid_in_reg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  output logic                           ready_o,
  input  wire logic [bid_pkg::BYTE_W-1:0] data_i,
  input  wire logic                      take_i,
  output logic                           valid_o,
  output logic [bid_pkg::BYTE_W-1:0]      data_o
);

  logic                       valid_q;
  logic [bid_pkg::BYTE_W-1:0] data_q;

  // free when empty or when the held byte is consumed this cycle
  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bid_decoder.sv
`default_nettype none

module bid_decoder (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_dump_en_i,
  input  wire logic                       fire_i,
  input  wire logic [bid_pkg::BYTE_W-1:0] byte_i,
  output logic                            emit_o,
  output bid_pkg::result_t                result_o
);

  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_TYPE,
    PH_IMM,
    PH_REG,
    PH_DEAD
  } phase_e;

  phase_e                         phase_q, phase_d;
  bid_pkg::kind_e                 opcode_q, opcode_d;
  logic [bid_pkg::VTYPE_W-1:0]    type_q, type_d;
  logic [bid_pkg::LEFT_W-1:0]     left_q, left_d;
  logic [bid_pkg::IMM_W-1:0]      acc_q, acc_d;
  logic [bid_pkg::REG_W-1:0]      reg1_q, reg1_d;
  logic                           dump_en_q;

  logic [bid_pkg::LEFT_W-1:0]     imm_len;
  logic [bid_pkg::LEFT_W-1:0]     left_dec;
  logic [bid_pkg::POS_W-1:0]      byte_pos;
  logic [bid_pkg::IMM_W-1:0]      acc_merged;
  logic [bid_pkg::IMM_W-1:0]      acc_final;
  logic                           byte_is_op;
  logic                           byte_bad_type;

  assign imm_len       = bid_pkg::imm_length(type_q);
  assign left_dec      = left_q - 1'b1;
  assign byte_pos      = bid_pkg::POS_W'(imm_len - left_q);
  assign acc_merged    = acc_q | (bid_pkg::IMM_W'(byte_i) << {byte_pos, 3'b000});
  assign byte_is_op    = (byte_i[7:4] == 4'd0);
  assign byte_bad_type = (byte_i > {4'd0, bid_pkg::TYPE_F64});

  // sign extension of the short signed types once the value is complete
  always_comb begin
    acc_final = acc_merged;
    if (type_q == bid_pkg::TYPE_I8) begin
      acc_final = {{56{acc_merged[7]}}, acc_merged[7:0]};
    end else if (type_q == bid_pkg::TYPE_I16) begin
      acc_final = {{48{acc_merged[15]}}, acc_merged[15:0]};
    end else if (type_q == bid_pkg::TYPE_I32) begin
      acc_final = {{32{acc_merged[31]}}, acc_merged[31:0]};
    end
  end

  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    type_d   = type_q;
    left_d   = left_q;
    acc_d    = acc_q;
    reg1_d   = reg1_q;
    emit_o   = 1'b0;
    result_o = '0;
    if (fire_i) begin
      case (phase_q)
        PH_OPCODE: begin
          if (byte_is_op) begin
            case (bid_pkg::kind_e'(byte_i[3:0]))
              bid_pkg::KIND_DUMP: begin
                if (dump_en_q) begin
                  emit_o        = 1'b1;
                  result_o.kind = bid_pkg::KIND_DUMP;
                end
              end
              bid_pkg::KIND_MOV, bid_pkg::KIND_PUSH: begin
                opcode_d = bid_pkg::kind_e'(byte_i[3:0]);
                phase_d  = PH_TYPE;
              end
              bid_pkg::KIND_POPR: begin
                opcode_d = bid_pkg::KIND_POPR;
                left_d   = 4'd1;
                phase_d  = PH_REG;
              end
              bid_pkg::KIND_COPYR, bid_pkg::KIND_GET, bid_pkg::KIND_SET: begin
                opcode_d = bid_pkg::kind_e'(byte_i[3:0]);
                left_d   = 4'd2;
                phase_d  = PH_REG;
              end
              bid_pkg::KIND_POP, bid_pkg::KIND_COPY, bid_pkg::KIND_SWAP: begin
                emit_o        = 1'b1;
                result_o.kind = bid_pkg::kind_e'(byte_i[3:0]);
              end
              default: begin
                // unknown opcode, skipped
              end
            endcase
          end
        end
        PH_TYPE: begin
          if (byte_bad_type) begin
            phase_d            = PH_DEAD;
            emit_o             = 1'b1;
            result_o.kind      = bid_pkg::KIND_BAD_TYPE;
            result_o.immediate = bid_pkg::IMM_W'(byte_i);
          end else begin
            type_d  = byte_i[3:0];
            left_d  = bid_pkg::imm_length(byte_i[3:0]);
            acc_d   = '0;
            phase_d = PH_IMM;
          end
        end
        PH_IMM: begin
          left_d = left_dec;
          if (left_dec != '0) begin
            acc_d = acc_merged;
          end else begin
            acc_d = acc_final;
            if (opcode_q == bid_pkg::KIND_MOV) begin
              left_d  = 4'd1;
              phase_d = PH_REG;
            end else begin
              phase_d             = PH_OPCODE;
              emit_o              = 1'b1;
              result_o.kind       = bid_pkg::KIND_PUSH;
              result_o.value_type = type_q;
              result_o.immediate  = acc_final;
            end
          end
        end
        PH_REG: begin
          if (left_q == 4'd2) begin
            reg1_d = byte_i;
            left_d = 4'd1;
          end else begin
            left_d  = '0;
            phase_d = PH_OPCODE;
            emit_o  = 1'b1;
            if (opcode_q == bid_pkg::KIND_MOV) begin
              result_o.kind       = bid_pkg::KIND_MOV;
              result_o.value_type = type_q;
              result_o.immediate  = acc_q;
              result_o.reg_first  = byte_i;
            end else if (opcode_q == bid_pkg::KIND_POPR) begin
              result_o.kind      = bid_pkg::KIND_POPR;
              result_o.reg_first = byte_i;
            end else begin
              result_o.kind       = opcode_q;
              result_o.reg_first  = reg1_q;
              result_o.reg_second = byte_i;
            end
          end
        end
        default: begin
          // dead after a bad type: discard everything
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_OPCODE;
      opcode_q  <= bid_pkg::KIND_DUMP;
      type_q    <= '0;
      left_q    <= '0;
      acc_q     <= '0;
      reg1_q    <= '0;
      dump_en_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      type_q   <= type_d;
      left_q   <= left_d;
      acc_q    <= acc_d;
      reg1_q   <= reg1_d;
      if (cfg_we_i) begin
        dump_en_q <= cfg_dump_en_i;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bid_out_reg.sv
`default_nettype none

module bid_out_reg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fire_i,
  input  wire logic                          emit_i,
  input  wire bid_pkg::result_t              result_i,
  output logic                               take_o,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output logic [bid_pkg::OUT_DATA_W-1:0]     data_o,
  output logic [bid_pkg::OUT_USER_W-1:0]     user_o
);

  logic             valid_q;
  bid_pkg::result_t result_q;

  // a new result may land when empty or when the held one leaves now
  assign take_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = {result_q.reg_second, result_q.reg_first, result_q.immediate};
  assign user_o  = {result_q.value_type, result_q.kind};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= fire_i && emit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && emit_i) begin
      result_q <= result_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bytecode_instruction_deframer.sv
// channel   dir  width  fields (lsb first)
// s_axis    in   8      tdata: data_byte
// m_axis    out  80/8   tdata: immediate, reg_first, reg_second; tuser: kind, value_type
// cfg       in   1      data: dump_enable
//
// one byte per cycle sustained while m_axis is not stalled; a result shows on m_axis once its
// last byte has passed the input register and then the result register around the decoder
// rst_ni clears the decode phase, held opcode/type, accumulator and dump_enable
// a stalled m_axis holds its word; s_axis keeps taking bytes while the input register
// is empty or the result register is empty or drains in the same cycle
`default_nettype none

module bytecode_instruction_deframer (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // byte stream in
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [bid_pkg::BYTE_W-1:0]         s_axis_tdata,   // [7:0] data_byte
  // decoded instructions out
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [63:0] immediate, [71:64] reg_first, [79:72] reg_second
  output logic [bid_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  // [3:0] kind, [7:4] value_type
  output logic [bid_pkg::OUT_USER_W-1:0]          m_axis_tuser,
  // dump_enable write
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic                               cfg_data_i
);

  logic                       byte_valid;
  logic [bid_pkg::BYTE_W-1:0] byte_data;
  logic                       out_take;
  logic                       fire;
  logic                       emit;
  bid_pkg::result_t           result;

  // the register write is always taken
  assign cfg_ready_o = 1'b1;

  // decoder steps whenever a byte is held and the result register can take a word
  assign fire = byte_valid && out_take;

  // input register
  bid_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (s_axis_tdata),
    .take_i  (fire),
    .valid_o (byte_valid),
    .data_o  (byte_data)
  );

  // phase tracking, operand assembly and result formation
  bid_decoder u_decoder (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_dump_en_i (cfg_data_i),
    .fire_i        (fire),
    .byte_i        (byte_data),
    .emit_o        (emit),
    .result_o      (result)
  );

  // result register
  bid_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .emit_i   (emit),
    .result_i (result),
    .take_o   (out_take),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .data_o   (m_axis_tdata),
    .user_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire

FILE: rtl/bid_checker.sv
`default_nettype none

`include "assert_macros.svh"

module bid_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               m_axis_tvalid,
  input wire logic                               m_axis_tready,
  input wire logic [bid_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input wire logic [bid_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

  logic [3:0] kind;
  logic [3:0] vtype;
  logic [7:0] reg2;
  logic       imm_kind;
  logic       two_reg_kind;

  assign kind  = m_axis_tuser[3:0];
  assign vtype = m_axis_tuser[7:4];
  assign reg2  = m_axis_tdata[79:72];

  assign imm_kind     = (kind == bid_pkg::KIND_MOV) || (kind == bid_pkg::KIND_PUSH);
  assign two_reg_kind = (kind == bid_pkg::KIND_COPYR) || (kind == bid_pkg::KIND_GET) ||
                        (kind == bid_pkg::KIND_SET);

  // a stalled word stays up
  `BID_ASSERT_NEXT(a_hold_valid, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // no kind beyond bad type
  `BID_ASSERT_SAME(a_kind_range, clk_i, rst_ni, m_axis_tvalid, kind <= bid_pkg::KIND_BAD_TYPE)

  // type tag only on mov and push
  `BID_ASSERT_SAME(a_vtype_kind, clk_i, rst_ni, m_axis_tvalid && vtype != 4'd0, imm_kind)

  // second register only on two-register instructions
  `BID_ASSERT_SAME(a_reg2_kind, clk_i, rst_ni, m_axis_tvalid && reg2 != 8'd0, two_reg_kind)

endmodule

bind bytecode_instruction_deframer bid_checker u_bid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: dv/tb_bytecode_instruction_deframer.sv
module tb_bytecode_instruction_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import bid_pkg::*;

  // cycles with no word moving on any channel before the run is called hung
  localparam int unsigned STALL_LIMIT = 2000;
  // a little slack after the last owed instruction has arrived
  localparam int unsigned DRAIN_CYCLES = 8;
  // counted instruction bytes per random phase
  localparam int unsigned PHASE_BYTES = 250;

  // decoder model plus the queue of instructions still owed by the block
  class deframer_scoreboard;
    typedef enum {P_OPCODE, P_TYPE, P_IMM, P_REG, P_HALTED} parse_e;

    bit                 dump_en;
    parse_e             parse;
    kind_e              op;
    logic [VTYPE_W-1:0] vtype;
    int unsigned        left;
    logic [IMM_W-1:0]   acc;
    logic [REG_W-1:0]   reg_a;

    result_t            pending_q[$];
    int unsigned        n_bytes;
    int unsigned        n_words;
    int unsigned        n_errors;
    int unsigned        kind_hits[11];

    function new();
      dump_en  = 1'b0;
      parse    = P_OPCODE;
      op       = KIND_DUMP;
      vtype    = '0;
      left     = 0;
      acc      = '0;
      reg_a    = '0;
      n_bytes  = 0;
      n_words  = 0;
      n_errors = 0;
    endfunction

    function int unsigned imm_bytes(logic [VTYPE_W-1:0] t);
      if (t == TYPE_F32) return 4;
      if (t == TYPE_F64) return 8;
      return 1 << t[1:0];
    endfunction

    function void owe(kind_e k, logic [VTYPE_W-1:0] t, logic [IMM_W-1:0] imm,
                      logic [REG_W-1:0] r1, logic [REG_W-1:0] r2);
      result_t r;
      r.kind       = k;
      r.value_type = t;
      r.immediate  = imm;
      r.reg_first  = r1;
      r.reg_second = r2;
      pending_q = {pending_q, r};
    endfunction

    // one accepted stream byte
    function void note_byte(logic [BYTE_W-1:0] b);
      int unsigned n;
      kind_e       k;
      n_bytes++;
      case (parse)
        P_OPCODE: begin
          // opcodes above swap are dropped silently
          if (b <= 8'(KIND_SWAP)) begin
            k = kind_e'(b[KIND_W-1:0]);
            case (k)
              KIND_DUMP: if (dump_en) owe(KIND_DUMP, '0, '0, '0, '0);
              KIND_MOV, KIND_PUSH: begin
                op    = k;
                parse = P_TYPE;
              end
              KIND_POPR: begin
                op    = k;
                left  = 1;
                parse = P_REG;
              end
              KIND_COPYR, KIND_GET, KIND_SET: begin
                op    = k;
                left  = 2;
                parse = P_REG;
              end
              default: owe(k, '0, '0, '0, '0);
            endcase
          end
        end
        P_TYPE: begin
          if (b > 8'(TYPE_F64)) begin
            // decoder locks up until reset
            parse = P_HALTED;
            owe(KIND_BAD_TYPE, '0, IMM_W'(b), '0, '0);
          end else begin
            vtype = b[VTYPE_W-1:0];
            left  = imm_bytes(vtype);
            acc   = '0;
            parse = P_IMM;
          end
        end
        P_IMM: begin
          n = imm_bytes(vtype);
          acc |= IMM_W'(b) << (8 * (n - left));
          left--;
          if (left == 0) begin
            if (vtype >= TYPE_I8 && vtype <= TYPE_I32 && acc[8*n-1])
              acc |= ~IMM_W'(0) << (8 * n);
            if (op == KIND_MOV) begin
              left  = 1;
              parse = P_REG;
            end else begin
              parse = P_OPCODE;
              owe(KIND_PUSH, vtype, acc, '0, '0);
            end
          end
        end
        P_REG: begin
          if (left == 2) begin
            reg_a = b;
            left  = 1;
          end else begin
            left  = 0;
            parse = P_OPCODE;
            if (op == KIND_MOV) owe(KIND_MOV, vtype, acc, b, '0);
            else if (op == KIND_POPR) owe(KIND_POPR, '0, '0, b, '0);
            else owe(op, '0, '0, reg_a, b);
          end
        end
        default: ;
      endcase
    endfunction

    function void complain(string what, result_t want, result_t got);
      n_errors++;
      if (n_errors <= 10) begin
        $display("%s word %0d: want kind %0d type %0d imm %h r1 %h r2 %h",
                 what, n_words, want.kind, want.value_type, want.immediate, want.reg_first,
                 want.reg_second);
        $display("  got kind %0d type %0d imm %h r1 %h r2 %h",
                 got.kind, got.value_type, got.immediate, got.reg_first, got.reg_second);
      end
    endfunction

    // one accepted instruction word
    function void check_word(result_t got);
      result_t want;
      n_words++;
      if (pending_q.size() == 0) begin
        want = '0;
        complain("unexpected", want, got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) complain("mismatch", want, got);
        else kind_hits[want.kind]++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [BYTE_W-1:0]     s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic                  cfg_data_i;

  deframer_scoreboard sb;
  bit                 no_idle;
  int unsigned        stall_cycles;
  int unsigned        cfg_writes;
  int unsigned        kinds_seen;

  bytecode_instruction_deframer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [7:0] data_byte
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [63:0] immediate, [71:64] reg_first, [79:72] reg_second
    .m_axis_tuser (m_axis_tuser),   // [3:0] kind, [7:4] value_type
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)      // dump_enable
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver backpressure: tready low about 15 percent of the time outside the no-idle stretch
  always @(negedge clk_i) begin
    m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 15);
  end

  // unpack and check every instruction word the block hands over
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind       = kind_e'(m_axis_tuser[KIND_W-1:0]);
      got.value_type = m_axis_tuser[KIND_W +: VTYPE_W];
      got.immediate  = m_axis_tdata[IMM_W-1:0];
      got.reg_first  = m_axis_tdata[IMM_W +: REG_W];
      got.reg_second = m_axis_tdata[IMM_W + REG_W +: REG_W];
      sb.check_word(got);
    end
  end

  // hang detection: any word on any channel restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("no progress for %0d cycles, %0d instructions still owed",
                 STALL_LIMIT, sb.pending_q.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // one stream byte; returns at the accepting edge with the model updated
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (!no_idle && $urandom_range(99) < 15) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b);
  endtask

  task automatic send_all(input logic [BYTE_W-1:0] q[$]);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // finish any half-sent instruction with zero bytes, then let the block go quiet
  task automatic drain_block();
    while (sb.parse != deframer_scoreboard::P_OPCODE &&
           sb.parse != deframer_scoreboard::P_HALTED)
      send_byte(8'h00);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_dump_enable(input bit v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.dump_en = v;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // register operand, biased toward the two extremes
  function automatic logic [REG_W-1:0] pick_reg();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'hff : 8'h00;
    return REG_W'($urandom_range(255));
  endfunction

  // one well-formed instruction with random operands
  function automatic void build_instr(ref logic [BYTE_W-1:0] q[$]);
    kind_e              k;
    logic [VTYPE_W-1:0] t;
    int unsigned        n;
    int unsigned        fill;
    k = kind_e'(KIND_W'($urandom_range(KIND_SWAP)));
    q = {q, BYTE_W'(k)};
    case (k)
      KIND_MOV, KIND_PUSH: begin
        t = VTYPE_W'($urandom_range(TYPE_F64));
        q = {q, BYTE_W'(t)};
        n    = (t == TYPE_F32) ? 4 : (t == TYPE_F64) ? 8 : (1 << t[1:0]);
        fill = $urandom_range(3);
        // all zeros, all ones, sign bit alone, or random bytes
        for (int unsigned i = 0; i < n; i++) begin
          case (fill)
            0:       q = {q, 8'h00};
            1:       q = {q, 8'hff};
            2:       q = {q, ((i == n - 1) ? 8'h80 : 8'h00)};
            default: q = {q, BYTE_W'($urandom_range(255))};
          endcase
        end
        if (k == KIND_MOV) q = {q, pick_reg()};
      end
      KIND_POPR: q = {q, pick_reg()};
      KIND_COPYR, KIND_GET, KIND_SET: begin
        q = {q, pick_reg()};
        q = {q, pick_reg()};
      end
      default: ;
    endcase
  endfunction

  // mostly whole instructions; some stray opcodes and some cut short
  task automatic run_random(input int unsigned budget);
    logic [BYTE_W-1:0] q[$];
    int unsigned       counted;
    int unsigned       roll;
    int unsigned       keep;
    counted = 0;
    while (counted < budget) begin
      q.delete();
      roll = $urandom_range(99);
      if (roll < 10) begin
        // unknown opcode, or 0x00 which depends on dump_enable
        q = {q, ($urandom_range(3) == 0 ? 8'h00 : BYTE_W'($urandom_range(255, 10)))};
      end else begin
        build_instr(q);
        // truncated instruction: the next bytes get swallowed as its operands
        if (roll < 18 && q.size() > 1) begin
          keep = $urandom_range(q.size() - 1, 1);
          while (q.size() > keep) void'(q.pop_back());
        end
        counted += q.size();
      end
      send_all(q);
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] q[$];
    sb            = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 1'b0;
    no_idle       = 1'b0;
    cfg_writes    = 0;
    stall_cycles  = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed, dump_enable still at its reset value
    q = '{8'h00, 8'h0a, 8'hff,                                // skipped opcodes
          8'h05, 8'h08, 8'h09,                                // pop, copy, swap
          8'h04, 8'h04, 8'h80,                                // push i8 most negative
          8'h04, 8'h05, 8'h00, 8'h80,                         // push i16 most negative
          8'h01, 8'h06, 8'h00, 8'h00, 8'h00, 8'h80, 8'hff,    // mov i32 into reg 0xff
          8'h02, 8'h00,                                       // popr
          8'h03, 8'hff, 8'h00,                                // copyr
          8'h06, 8'h01, 8'h02,                                // get
          8'h07, 8'h02, 8'h01};                               // set
    send_all(q);
    drain_block();

    // opcode zero becomes dump
    write_dump_enable(1'b1);
    q = '{8'h00, 8'h00};
    send_all(q);
    drain_block();

    // random phases with dump_enable flipping between them
    run_random(PHASE_BYTES);
    drain_block();
    write_dump_enable(1'b0);
    no_idle = 1'b1;
    run_random(PHASE_BYTES);
    drain_block();
    no_idle = 1'b0;
    write_dump_enable(1'b1);
    run_random(PHASE_BYTES);
    drain_block();
    write_dump_enable(1'b0);
    run_random(PHASE_BYTES);
    drain_block();
    write_dump_enable(1'b1);

    // bad type byte last: the decoder ignores everything after it
    q.delete();
    q = {q, 8'h04};
    q = {q, BYTE_W'($urandom_range(255, 10))};
    for (int i = 0; i < 16; i++) q = {q, BYTE_W'($urandom_range(255))};
    send_all(q);
    drain_block();

    foreach (sb.pending_q[i]) begin
      sb.n_errors++;
      $display("instruction %0d never arrived: kind %0d", i, sb.pending_q[i].kind);
    end
    kinds_seen = 0;
    foreach (sb.kind_hits[i]) if (sb.kind_hits[i] != 0) kinds_seen++;
    $display("run: %0d stream bytes in, %0d instruction words out, %0d of 11 kinds decoded",
             sb.n_bytes, sb.n_words, kinds_seen);
    $display("run: %0d dump_enable writes, %0d failures", cfg_writes, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bid_pkg.sv
rtl/bid_in_reg.sv
rtl/bid_decoder.sv
rtl/bid_out_reg.sv
rtl/bytecode_instruction_deframer.sv
rtl/bid_checker.sv
dv/tb_bytecode_instruction_deframer.sv
